// ===== rtl/core/bdq_pkg.sv =====
// Shared types, codes and constants of the bounded double-ended queue.
package bdq_pkg;

   localparam int WORD_W        = 32;
   localparam int CSR_W         = 5;
   localparam int OCC_W         = 5;
   localparam int DEFAULT_DEPTH = 16;

   localparam logic [CSR_W-1:0]         CAPACITY_RESET = 5'd16;
   localparam logic signed [WORD_W-1:0] EMPTY_WORD     = '1;

   typedef enum logic [1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_REAR  = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_POP_REAR   = 2'd3
   } action_type;

   // Per-cycle command broadcast to every cell
   typedef enum logic [2:0] {
      CELL_HOLD       = 3'd0,
      CELL_SHIFT_BACK = 3'd1,   // push front: every word moves one cell rearward
      CELL_SHIFT_FWD  = 3'd2,   // pop front: every word moves one cell frontward
      CELL_FILL       = 3'd3,   // push rear: first empty cell takes the word
      CELL_DROP       = 3'd4,   // pop rear: last full cell empties
      CELL_FLUSH      = 3'd5    // capacity write: all cells empty
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [WORD_W-1:0] data;
   } cell_ctl_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] word;
      logic                     valid;
   } link_type;

   typedef struct packed {
      action_type               action;
      logic signed [WORD_W-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic                     accepted;
      logic signed [WORD_W-1:0] front_word;
      logic signed [WORD_W-1:0] rear_word;
      logic                     empty_flag;
      logic                     full_flag;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

endpackage

// ===== rtl/core/bdq_cell.sv =====
// One storage cell of the queue chain: a word and its valid bit.
module bdq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  bdq_pkg::cell_ctl_type ctl,
   input  bdq_pkg::link_type     prev_link,   // neighbor toward the front
   input  bdq_pkg::link_type     next_link,   // neighbor toward the rear
   output bdq_pkg::link_type     cell_link,
   output logic                  is_rear
);

   logic signed [bdq_pkg::WORD_W-1:0] word_ff, word_in;
   logic                              valid_ff, valid_in;

   always_comb begin
      word_in  = word_ff;
      valid_in = valid_ff;
      case (ctl.op)
         bdq_pkg::CELL_SHIFT_BACK: begin
            word_in  = prev_link.word;
            valid_in = prev_link.valid;
         end
         bdq_pkg::CELL_SHIFT_FWD: begin
            word_in  = next_link.word;
            valid_in = next_link.valid;
         end
         bdq_pkg::CELL_FILL: begin
            if (!valid_ff && prev_link.valid) begin
               word_in  = ctl.data;
               valid_in = 1'b1;
            end
         end
         bdq_pkg::CELL_DROP: begin
            if (valid_ff && !next_link.valid) begin
               valid_in = 1'b0;
            end
         end
         bdq_pkg::CELL_FLUSH: begin
            valid_in = 1'b0;
         end
         default: begin
            word_in  = word_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign cell_link.word  = word_ff;
   assign cell_link.valid = valid_ff;
   assign is_rear         = valid_ff && !next_link.valid;

endmodule

// ===== rtl/core/bounded_double_ended_queue.sv =====
// Top level of the bounded double-ended queue: control, cell chain and result register.
//
// A bounded deque of signed 32-bit words held in a row of DEPTH cells. The
// front word always sits in cell 0 and the held words fill cells 0..count-1
// contiguously. A push at the front shifts the whole row one cell rearward,
// a pop at the front shifts it one cell frontward, a push at the rear fills
// the first empty cell and a pop at the rear empties the last full one; all
// four update the cell registers directly. Each request beat yields exactly one
// response beat reporting whether the action was done plus the front word,
// rear word, empty and full flags and the count after the action (front and
// rear read -1 when empty). The block accepts a new request every cycle as
// long as the response register is empty or is being drained in the same
// cycle, so with rsp_ready held high it sustains one request per clock. The
// capacity register (reset 16) saturates at DEPTH; writing it empties the
// queue. Write it only while no request is in flight. Capacity 0 refuses
// every push and pop.
module bounded_double_ended_queue #(
   parameter int DEPTH = bdq_pkg::DEFAULT_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bdq_pkg::req_type            req_payload,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bdq_pkg::rsp_type            rsp_payload,
   // capacity register
   input  logic                        csr_write_enable,
   input  logic [bdq_pkg::CSR_W-1:0]   csr_write_data
);

   // Largest capacity the chain can honor, clipped to the register range.
   localparam int                         CapLimitInt = (DEPTH < 31) ? DEPTH : 31;
   localparam logic [bdq_pkg::CSR_W-1:0] CAP_LIMIT   = bdq_pkg::CSR_W'(CapLimitInt);

   logic [bdq_pkg::CSR_W-1:0] capacity_ff, capacity_in;
   logic [bdq_pkg::OCC_W-1:0] count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      accepted_ff, accepted_in;

   logic [bdq_pkg::CSR_W-1:0] eff_capacity;
   logic                      req_fire;
   logic                      can_push;
   logic                      can_pop;
   logic                      done;
   bdq_pkg::cell_ctl_type     cell_ctl;

   bdq_pkg::link_type         cell_link [DEPTH];
   logic [DEPTH-1:0]          is_rear;
   logic signed [bdq_pkg::WORD_W-1:0] rear_ored;

   assign eff_capacity = (capacity_ff > CAP_LIMIT) ? CAP_LIMIT : capacity_ff;

   // The response register frees up when empty or when drained this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign can_push = {1'b0, count_ff} < {1'b0, eff_capacity};
   assign can_pop  = count_ff != '0;

   // Decode the beat into a cell command and the new count.
   always_comb begin
      cell_ctl.op   = bdq_pkg::CELL_HOLD;
      cell_ctl.data = req_payload.data_value;
      done          = 1'b0;
      count_in      = count_ff;
      if (csr_write_enable) begin
         cell_ctl.op = bdq_pkg::CELL_FLUSH;
         count_in    = '0;
      end else if (req_fire) begin
         case (req_payload.action)
            bdq_pkg::ACT_PUSH_FRONT: begin
               done = can_push;
               if (can_push) begin
                  cell_ctl.op = bdq_pkg::CELL_SHIFT_BACK;
               end
            end
            bdq_pkg::ACT_PUSH_REAR: begin
               done = can_push;
               if (can_push) begin
                  cell_ctl.op = bdq_pkg::CELL_FILL;
               end
            end
            bdq_pkg::ACT_POP_FRONT: begin
               done = can_pop;
               if (can_pop) begin
                  cell_ctl.op = bdq_pkg::CELL_SHIFT_FWD;
               end
            end
            bdq_pkg::ACT_POP_REAR: begin
               done = can_pop;
               if (can_pop) begin
                  cell_ctl.op = bdq_pkg::CELL_DROP;
               end
            end
            default: begin
               done = 1'b0;
            end
         endcase
         if (done) begin
            if (req_payload.action == bdq_pkg::ACT_PUSH_FRONT ||
                req_payload.action == bdq_pkg::ACT_PUSH_REAR) begin
               count_in = count_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   always_comb begin
      capacity_in  = csr_write_enable ? csr_write_data : capacity_ff;
      accepted_in  = req_fire ? done : accepted_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= bdq_pkg::CAPACITY_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         accepted_ff  <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         accepted_ff  <= accepted_in;
      end
   end

   // Cell chain: cell 0 is the front. The front end of the chain sees the
   // incoming word as an always-valid neighbor; the rear end sees an empty one.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bdq_pkg::link_type prev_link;
      bdq_pkg::link_type next_link;

      if (i == 0) begin : g_head
         assign prev_link.word  = req_payload.data_value;
         assign prev_link.valid = 1'b1;
      end else begin : g_body
         assign prev_link = cell_link[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_link.word  = '0;
         assign next_link.valid = 1'b0;
      end else begin : g_inner
         assign next_link = cell_link[i+1];
      end

      bdq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .prev_link (prev_link),
         .next_link (next_link),
         .cell_link (cell_link[i]),
         .is_rear   (is_rear[i])
      );
   end

   // Exactly one cell flags itself as rear when the queue holds words.
   always_comb begin
      rear_ored = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (is_rear[i]) begin
            rear_ored = rear_ored | cell_link[i].word;
         end
      end
   end

   // Response fields come straight from the registered state; it is frozen
   // while the beat waits because no new request is taken until it drains (a capacity write would still change it).
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_payload.accepted   = accepted_ff;
   assign rsp_payload.front_word = cell_link[0].valid ? cell_link[0].word
                                                      : bdq_pkg::EMPTY_WORD;
   assign rsp_payload.rear_word  = (count_ff != '0) ? rear_ored : bdq_pkg::EMPTY_WORD;
   assign rsp_payload.empty_flag = count_ff == '0;
   assign rsp_payload.full_flag  = count_ff == eff_capacity;
   assign rsp_payload.occupancy  = count_ff;

endmodule
